FILE: src/ehp_pkg.sv
package ehp_pkg;

  localparam int unsigned CountW = 7;

  typedef logic [CountW-1:0] pos_t;

  // Byte count saturates here; no header byte past position 77 is ever used
  localparam pos_t CountMax = '1;

  localparam logic [15:0] EtypeIpv4 = 16'h0800;
  localparam logic [15:0] EtypeIpv6 = 16'h86dd;
  localparam logic [7:0]  ProtoTcp  = 8'd6;
  localparam logic [7:0]  ProtoUdp  = 8'd17;
  localparam logic [3:0]  VerIpv4   = 4'd4;
  localparam logic [3:0]  VerIpv6   = 4'd6;
  localparam logic [15:0] FragOffMask = 16'h1fff;
  localparam logic [5:0]  MinIhlBytes = 6'd20;

  // Byte positions within the frame
  localparam pos_t PosSrcMac  = 7'd6;
  localparam pos_t PosType    = 7'd12;
  localparam pos_t PosVerIhl  = 7'd14;
  localparam pos_t PosTotLen  = 7'd16;
  localparam pos_t PosPayLen  = 7'd18;
  localparam pos_t PosFrag    = 7'd20;
  localparam pos_t PosV4Proto = 7'd23;
  localparam pos_t PosV6Proto = 7'd20;
  localparam pos_t PosV6L4    = 7'd54;
  localparam pos_t PosV6L4End = 7'd58;
  localparam pos_t L4Bytes    = 7'd4;

  // Frame lengths that gate each decision
  localparam pos_t MinEthLen     = 7'd14;
  localparam pos_t MinIpLen      = 7'd15;
  localparam pos_t MinV4ProtoLen = 7'd24;
  localparam pos_t MinV6ProtoLen = 7'd21;

  typedef struct packed {
    pos_t        count;
    logic [47:0] dst_addr;
    logic [47:0] src_addr;
    logic [15:0] etype;
    logic [7:0]  ver_ihl;
    logic [7:0]  proto;
    logic [15:0] total_len;
    logic [15:0] frag_word;
    logic [15:0] pay_len;
    logic [31:0] port_bytes;
  } hdr_t;

  typedef struct packed {
    logic        status;
    logic [47:0] dst_mac;
    logic [47:0] src_mac;
    logic [15:0] eth_type;
    logic        is_ipv4;
    logic        is_ipv6;
    logic [7:0]  l3_proto;
    logic        ports_ok;
    logic [15:0] sport;
    logic [15:0] dport;
  } result_t;

endpackage

FILE: src/ehp_if.sv
interface ehp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ehp_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [47:0] dst_mac;
  logic [47:0] src_mac;
  logic [15:0] eth_type;
  logic        is_ipv4;
  logic        is_ipv6;
  logic [7:0]  l3_proto;
  logic        ports_ok;
  logic [15:0] sport;
  logic [15:0] dport;

  modport source (
    output valid, output status, output dst_mac, output src_mac, output eth_type,
    output is_ipv4, output is_ipv6, output l3_proto, output ports_ok,
    output sport, output dport, input ready
  );
  modport sink (
    input valid, input status, input dst_mac, input src_mac, input eth_type,
    input is_ipv4, input is_ipv6, input l3_proto, input ports_ok,
    input sport, input dport, output ready
  );
endinterface

FILE: src/ehp_capture.sv
module ehp_capture (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic [7:0]    data_byte_i,
  input  logic          last_byte_i,
  output ehp_pkg::hdr_t hdr_o
);

  ehp_pkg::hdr_t hdr_q, hdr_d;
  ehp_pkg::pos_t pos;
  logic [5:0]    ihl_bytes;
  ehp_pkg::pos_t l4_pos;
  ehp_pkg::pos_t l4_end;

  always_comb begin
    hdr_d     = hdr_q;
    pos       = hdr_q.count;
    ihl_bytes = {hdr_q.ver_ihl[3:0], 2'b00};
    l4_pos    = ehp_pkg::PosVerIhl + {1'b0, ihl_bytes};
    l4_end    = l4_pos + ehp_pkg::L4Bytes;

    if (pos < ehp_pkg::PosSrcMac) begin
      hdr_d.dst_addr = {hdr_q.dst_addr[39:0], data_byte_i};
    end else if (pos < ehp_pkg::PosType) begin
      hdr_d.src_addr = {hdr_q.src_addr[39:0], data_byte_i};
    end else if (pos < ehp_pkg::PosVerIhl) begin
      hdr_d.etype = {hdr_q.etype[7:0], data_byte_i};
    end else if (pos == ehp_pkg::PosVerIhl) begin
      hdr_d.ver_ihl = data_byte_i;
    end

    if (pos inside {[ehp_pkg::PosTotLen:ehp_pkg::PosTotLen + 7'd1]}) begin
      hdr_d.total_len = {hdr_q.total_len[7:0], data_byte_i};
    end
    if (pos inside {[ehp_pkg::PosPayLen:ehp_pkg::PosPayLen + 7'd1]}) begin
      hdr_d.pay_len = {hdr_q.pay_len[7:0], data_byte_i};
    end
    if (pos inside {[ehp_pkg::PosFrag:ehp_pkg::PosFrag + 7'd1]}) begin
      hdr_d.frag_word = {hdr_q.frag_word[7:0], data_byte_i};
    end

    // EtherType and version/IHL are final once past the version byte
    if (hdr_q.etype == ehp_pkg::EtypeIpv4 && pos > ehp_pkg::PosVerIhl) begin
      if (pos == ehp_pkg::PosV4Proto) begin
        hdr_d.proto = data_byte_i;
      end
      if (pos >= l4_pos && pos < l4_end) begin
        hdr_d.port_bytes = {hdr_q.port_bytes[23:0], data_byte_i};
      end
    end else if (hdr_q.etype == ehp_pkg::EtypeIpv6 && pos > ehp_pkg::PosVerIhl) begin
      if (pos == ehp_pkg::PosV6Proto) begin
        hdr_d.proto = data_byte_i;
      end
      if (pos >= ehp_pkg::PosV6L4 && pos < ehp_pkg::PosV6L4End) begin
        hdr_d.port_bytes = {hdr_q.port_bytes[23:0], data_byte_i};
      end
    end

    hdr_d.count = (pos != ehp_pkg::CountMax) ? pos + 7'd1 : pos;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q <= '0;
    end else if (step_i) begin
      hdr_q <= last_byte_i ? '0 : hdr_d;
    end
  end

  // Record is built from the state including the final byte
  assign hdr_o = hdr_d;

endmodule

FILE: src/ehp_eval.sv
module ehp_eval (
  input  ehp_pkg::hdr_t    hdr_i,
  output ehp_pkg::result_t res_o
);

  ehp_pkg::pos_t len;
  logic [3:0]    ver;
  logic [5:0]    ihl_bytes;
  ehp_pkg::pos_t ihl_p4;
  ehp_pkg::pos_t v4_l4_end;
  logic          l4_proto;

  always_comb begin
    len       = hdr_i.count;
    ver       = hdr_i.ver_ihl[7:4];
    ihl_bytes = {hdr_i.ver_ihl[3:0], 2'b00};
    ihl_p4    = {1'b0, ihl_bytes} + ehp_pkg::L4Bytes;
    v4_l4_end = ehp_pkg::PosVerIhl + ihl_p4;
    l4_proto  = (hdr_i.proto == ehp_pkg::ProtoTcp) || (hdr_i.proto == ehp_pkg::ProtoUdp);

    res_o = '0;
    if (len < ehp_pkg::MinEthLen) begin
      res_o.status = 1'b1;
    end else begin
      res_o.dst_mac  = hdr_i.dst_addr;
      res_o.src_mac  = hdr_i.src_addr;
      res_o.eth_type = hdr_i.etype;
      if (hdr_i.etype == ehp_pkg::EtypeIpv4) begin
        if (len < ehp_pkg::MinIpLen || ver != ehp_pkg::VerIpv4 ||
            ihl_bytes < ehp_pkg::MinIhlBytes) begin
          res_o.status = 1'b1;
        end else begin
          res_o.is_ipv4 = 1'b1;
          if (len >= ehp_pkg::MinV4ProtoLen) begin
            res_o.l3_proto = hdr_i.proto;
            if (hdr_i.total_len < {10'd0, ihl_bytes}) begin
              res_o.status = 1'b1;
            end else if (len >= v4_l4_end && (hdr_i.frag_word & ehp_pkg::FragOffMask) == '0 &&
                         l4_proto && hdr_i.total_len >= {9'd0, ihl_p4}) begin
              res_o.ports_ok = 1'b1;
              res_o.sport    = hdr_i.port_bytes[31:16];
              res_o.dport    = hdr_i.port_bytes[15:0];
            end
          end
        end
      end else if (hdr_i.etype == ehp_pkg::EtypeIpv6) begin
        if (len < ehp_pkg::MinIpLen || ver != ehp_pkg::VerIpv6) begin
          res_o.status = 1'b1;
        end else begin
          res_o.is_ipv6 = 1'b1;
          if (len >= ehp_pkg::MinV6ProtoLen) begin
            res_o.l3_proto = hdr_i.proto;
            if (len >= ehp_pkg::PosV6L4End && l4_proto &&
                hdr_i.pay_len >= {9'd0, ehp_pkg::L4Bytes}) begin
              res_o.ports_ok = 1'b1;
              res_o.sport    = hdr_i.port_bytes[31:16];
              res_o.dport    = hdr_i.port_bytes[15:0];
            end
          end
        end
      end
    end
  end

endmodule

FILE: src/eth_ip_header_parser_top.sv
// Ethernet/IPv4/IPv6 header parser. Frame bytes enter one item per cycle,
// with last_byte set on the final byte; that byte produces one record with
// MACs, EtherType, IP version flags, protocol, TCP/UDP ports and a status,
// and no other byte produces anything. Sustained rate is one byte per clock
// unless a held record stalls input. A byte passes an input register, then
// is captured into the header state while the record for a final byte is
// evaluated into the result register: the record is presented from the
// result register after its last byte has passed both. Input stalls only
// while the result register holds a record not yet taken.
// IPv6 extension headers are not walked; ports are read at byte 54.
module eth_ip_header_parser_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  ehp_in_if.sink    in_i,
  ehp_out_if.source out_o
);

  logic             in_valid_q;
  logic [7:0]       byte_q;
  logic             last_q;
  logic             out_valid_q;
  ehp_pkg::result_t res_q;
  ehp_pkg::result_t res_d;
  ehp_pkg::hdr_t    hdr;
  logic             step;

  assign step       = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      byte_q <= in_i.data_byte;
      last_q <= in_i.last_byte;
    end
  end

  ehp_capture u_capture (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .data_byte_i (byte_q),
    .last_byte_i (last_q),
    .hdr_o       (hdr)
  );

  ehp_eval u_eval (
    .hdr_i (hdr),
    .res_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= last_q;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && last_q) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.status   = res_q.status;
  assign out_o.dst_mac  = res_q.dst_mac;
  assign out_o.src_mac  = res_q.src_mac;
  assign out_o.eth_type = res_q.eth_type;
  assign out_o.is_ipv4  = res_q.is_ipv4;
  assign out_o.is_ipv6  = res_q.is_ipv6;
  assign out_o.l3_proto = res_q.l3_proto;
  assign out_o.ports_ok = res_q.ports_ok;
  assign out_o.sport    = res_q.sport;
  assign out_o.dport    = res_q.dport;

  a_last_gives_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && last_q |=> out_valid_q && res_q == $past(res_d))
    else $error("final byte did not load a record");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && !out_o.ready |-> !in_i.ready)
    else $error("input taken while held record blocks the pipe");

  a_ports_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.ports_ok |->
      !res_q.status && (res_q.is_ipv4 || res_q.is_ipv6) &&
      (res_q.l3_proto == ehp_pkg::ProtoTcp || res_q.l3_proto == ehp_pkg::ProtoUdp))
    else $error("ports reported on a record that cannot carry them");

  a_one_ip_version: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(res_q.is_ipv4 && res_q.is_ipv6))
    else $error("record flags both IPv4 and IPv6");

endmodule
